/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the scheduler RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checks a property on every rising edge of clk_i outside reset.
`define MPTS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("scheduler assertion failed");
// Checks that a condition never holds.
`define MPTS_ASSERT_NEVER(name, cond) `MPTS_ASSERT(name, !(cond))
`else
`define MPTS_ASSERT(name, prop)
`define MPTS_ASSERT_NEVER(name, cond)
`endif

`endif

/* hdl/mpts_pkg.sv */
// ---------------------------------------------------------------------------
// mpts_pkg
// Types, codes and constants shared by the scheduler controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package mpts_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int MAX_CPUS_DEF  = 4;
  localparam int TIME_BITS     = 16;

  localparam int ID_W       = 8;
  localparam int PRIO_W     = 8;
  localparam int KIND_W     = 2;
  localparam int CPU_IDX_W  = 3;
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int LFSR_W     = 16;
  localparam int STAT_W     = 2;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  localparam logic POLICY_PRIOP = 1'b0;
  localparam logic POLICY_SRTF  = 1'b1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [STAT_W-1:0] ST_NEW   = 2'd0;
  localparam logic [STAT_W-1:0] ST_READY = 2'd1;
  localparam logic [STAT_W-1:0] ST_RUN   = 2'd2;
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd3;

  localparam logic [KIND_W-1:0] KIND_LOAD_OK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_FULL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CPU       = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ALL_DONE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CPUS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_ADMIT,
    OP_SEL_INIT,
    OP_SEL_STEP,
    OP_PLACE,
    OP_VIC_STEP,
    OP_SWAP1,
    OP_SWAP2,
    OP_RUN_STEP,
    OP_EMIT_ONE,
    OP_EMIT_CPU,
    OP_CNT_CLR
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic all_fin;
    logic idx_ge_loaded;
    logic idx_ge_ready;
    logic ready_empty;
    logic free_found;
    logic vic_found;
    logic idx_ge_ncpu;
    logic idx_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* hdl/mpts_ctrl.sv */
// ---------------------------------------------------------------------------
// mpts_ctrl
// Sequencer that walks a tick through admission, selection, placement,
// preemption, execution and reporting.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mpts_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire mpts_pkg::stat_t st_i,
  output mpts_pkg::cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ADMIT    = 4'd1;
  localparam logic [3:0] S_SEL_INIT = 4'd2;
  localparam logic [3:0] S_SEL_SCAN = 4'd3;
  localparam logic [3:0] S_PLACE    = 4'd4;
  localparam logic [3:0] S_VIC_SCAN = 4'd5;
  localparam logic [3:0] S_SWAP1    = 4'd6;
  localparam logic [3:0] S_SWAP2    = 4'd7;
  localparam logic [3:0] S_RUN      = 4'd8;
  localparam logic [3:0] S_EMIT_CPU = 4'd9;
  localparam logic [3:0] S_EMIT_ONE = 4'd10;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = mpts_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = mpts_pkg::OP_ACCEPT;
          if (!st_i.is_tick || st_i.all_fin) state_d = S_EMIT_ONE;
          else state_d = S_ADMIT;
        end
      end
      S_ADMIT: begin
        if (st_i.idx_ge_loaded) state_d = S_SEL_INIT;
        else cmd_o.op = mpts_pkg::OP_ADMIT;
      end
      S_SEL_INIT: begin
        if (st_i.ready_empty) begin
          cmd_o.op = mpts_pkg::OP_CNT_CLR;
          state_d  = S_RUN;
        end else begin
          cmd_o.op = mpts_pkg::OP_SEL_INIT;
          state_d  = S_SEL_SCAN;
        end
      end
      S_SEL_SCAN: begin
        if (st_i.idx_ge_ready) state_d = S_PLACE;
        else cmd_o.op = mpts_pkg::OP_SEL_STEP;
      end
      S_PLACE: begin
        cmd_o.op = mpts_pkg::OP_PLACE;
        state_d  = st_i.free_found ? S_SEL_INIT : S_VIC_SCAN;
      end
      S_VIC_SCAN: begin
        if (!st_i.idx_ge_ncpu) begin
          cmd_o.op = mpts_pkg::OP_VIC_STEP;
        end else if (st_i.vic_found) begin
          state_d = S_SWAP1;
        end else begin
          cmd_o.op = mpts_pkg::OP_CNT_CLR;
          state_d  = S_RUN;
        end
      end
      S_SWAP1: begin
        cmd_o.op = mpts_pkg::OP_SWAP1;
        state_d  = S_SWAP2;
      end
      S_SWAP2: begin
        cmd_o.op = mpts_pkg::OP_SWAP2;
        state_d  = S_SEL_INIT;
      end
      S_RUN: begin
        if (st_i.idx_ge_ncpu) begin
          cmd_o.op = mpts_pkg::OP_CNT_CLR;
          state_d  = S_EMIT_CPU;
        end else begin
          cmd_o.op = mpts_pkg::OP_RUN_STEP;
        end
      end
      S_EMIT_CPU: begin
        if (st_i.out_free) begin
          cmd_o.op = mpts_pkg::OP_EMIT_CPU;
          if (st_i.idx_last) state_d = S_IDLE;
        end
      end
      S_EMIT_ONE: begin
        if (st_i.out_free) begin
          cmd_o.op = mpts_pkg::OP_EMIT_ONE;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `MPTS_ASSERT(a_emit_needs_room, (cmd_o.op == mpts_pkg::OP_EMIT_CPU || cmd_o.op == mpts_pkg::OP_EMIT_ONE) |-> st_i.out_free)

endmodule

`default_nettype wire

/* hdl/mpts_dp.sv */
// ---------------------------------------------------------------------------
// mpts_dp
// Task table, ready queue, processor slots, configuration registers and the
// output register of the scheduler.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mpts_dp #(
  parameter int MAX_TASKS = mpts_pkg::MAX_TASKS_DEF,
  parameter int MAX_CPUS  = mpts_pkg::MAX_CPUS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire mpts_pkg::cmd_t                   cmd_i,
  output mpts_pkg::stat_t                       st_o,
  input  wire logic                             func_i,
  input  wire logic [mpts_pkg::ID_W-1:0]        task_id_i,
  input  wire logic [mpts_pkg::TIME_BITS-1:0]   arrival_time_i,
  input  wire logic [mpts_pkg::TIME_BITS-1:0]   duration_i,
  input  wire logic [mpts_pkg::PRIO_W-1:0]      priority_req_i,
  input  wire logic                             cfg_valid_i,
  input  wire logic [mpts_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [mpts_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output logic [mpts_pkg::KIND_W-1:0]           kind_o,
  output logic [mpts_pkg::CPU_IDX_W-1:0]        cpu_index_o,
  output logic [mpts_pkg::ID_W-1:0]             running_id_o,
  output logic [mpts_pkg::TIME_BITS-1:0]        remaining_o,
  output logic                                  busy_res_o,
  output logic                                  finished_o,
  output logic [mpts_pkg::TIME_BITS-1:0]        tick_value_o,
  output logic                                  all_done_o,
  output logic                                  last_o
);

  localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int LW = $clog2(MAX_TASKS + 1);
  localparam int CW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int NW = $clog2(MAX_CPUS + 1);
  localparam int IW = (LW > NW) ? LW : NW;
  localparam int TB = mpts_pkg::TIME_BITS;
  localparam int DW = mpts_pkg::ID_W;
  localparam int PW = mpts_pkg::PRIO_W;
  localparam int SW = mpts_pkg::STAT_W;
  localparam int RW = mpts_pkg::LFSR_W;

  // Configuration and tie-break state.
  logic                       policy_q;
  logic [mpts_pkg::CNT_W-1:0] cpu_count_q;
  logic [RW-1:0]              lfsr_q, lfsr_next;

  // Task table.
  logic [DW-1:0] ident_q [MAX_TASKS];
  logic [TB-1:0] arr_q   [MAX_TASKS];
  logic [TB-1:0] len_q   [MAX_TASKS];
  logic [TB-1:0] left_q  [MAX_TASKS];
  logic [PW-1:0] urg_q   [MAX_TASKS];
  logic [SW-1:0] stat_q  [MAX_TASKS];

  // Ready queue and processors.
  logic [TW-1:0] rq_q [MAX_TASKS];
  logic [LW-1:0] ready_len_q;
  logic [TW-1:0] slot_q [MAX_CPUS];
  logic [MAX_CPUS-1:0] cvalid_q;

  logic [TB-1:0] clock_q;
  logic [LW-1:0] done_q, loaded_q;
  logic [IW-1:0] idx_q;
  logic [TW-1:0] idx_t;
  logic [CW-1:0] idx_c;

  // Current best candidate and victim search.
  logic [TW-1:0] best_pos_q, best_task_q;
  logic [PW-1:0] best_urg_q, ref_urg_q;
  logic [TB-1:0] best_left_q, best_arr_q, best_len_q, ref_left_q;
  logic [CW-1:0] victim_q;
  logic          vic_found_q;

  // Per-processor results of the current tick.
  logic [DW-1:0] r_id_q   [MAX_CPUS];
  logic [TB-1:0] r_rem_q  [MAX_CPUS];
  logic          r_busy_q [MAX_CPUS];
  logic          r_fin_q  [MAX_CPUS];

  logic [mpts_pkg::KIND_W-1:0] res_kind_q;

  // Single read port into the task table.
  logic [TW-1:0] rd_idx;
  logic [DW-1:0] rd_ident;
  logic [TB-1:0] rd_arr, rd_len, rd_left;
  logic [PW-1:0] rd_urg;
  logic [SW-1:0] rd_stat;

  logic [NW-1:0] ncpu;
  logic          all_fin, out_free, idx_last, load_room, admit_hit;
  logic          free_found;
  logic [CW-1:0] free_cpu;
  logic          b_worse, c_worse, cand_wins, lfsr_used, vic_worse;
  logic [TB-1:0] new_left;
  logic [TW-1:0] rq_tail;

  assign idx_t   = idx_q[TW-1:0];
  assign idx_c   = idx_q[CW-1:0];
  assign rq_tail = TW'(ready_len_q - 1'b1);

  always_comb begin
    case (cmd_i.op)
      mpts_pkg::OP_ADMIT:    rd_idx = idx_t;
      mpts_pkg::OP_SEL_INIT: rd_idx = rq_q[0];
      mpts_pkg::OP_SEL_STEP: rd_idx = rq_q[idx_t];
      mpts_pkg::OP_VIC_STEP,
      mpts_pkg::OP_RUN_STEP: rd_idx = slot_q[idx_c];
      default:               rd_idx = best_task_q;
    endcase
  end

  assign rd_ident = ident_q[rd_idx];
  assign rd_arr   = arr_q[rd_idx];
  assign rd_len   = len_q[rd_idx];
  assign rd_left  = left_q[rd_idx];
  assign rd_urg   = urg_q[rd_idx];
  assign rd_stat  = stat_q[rd_idx];

  // A count of zero runs one processor; a count above the build limit is clamped.
  always_comb begin
    if (cpu_count_q == '0) ncpu = NW'(1);
    else if (32'(cpu_count_q) > MAX_CPUS) ncpu = NW'(MAX_CPUS);
    else ncpu = NW'(cpu_count_q);
  end

  assign all_fin   = (loaded_q != '0) && (done_q >= loaded_q);
  assign out_free  = !out_valid_o || out_ready_i;
  assign idx_last  = ((idx_q + 1) == ncpu);
  assign load_room = (32'(loaded_q) < MAX_TASKS);
  assign admit_hit = (rd_stat == mpts_pkg::ST_NEW) && (rd_arr == clock_q);
  assign new_left  = (rd_left == '0) ? '0 : rd_left - 1'b1;
  assign lfsr_next = {1'b0, lfsr_q[RW-1:1]} ^ (lfsr_q[0] ? mpts_pkg::LFSR_TAPS : '0);

  // Lowest-numbered idle processor among those in use.
  always_comb begin
    free_found = 1'b0;
    free_cpu   = '0;
    for (int i = MAX_CPUS - 1; i >= 0; i--) begin
      if ((i < ncpu) && !cvalid_q[i]) begin
        free_found = 1'b1;
        free_cpu   = CW'(i);
      end
    end
  end

  // Candidate against the current best: key, then arrival, then length, then LFSR.
  always_comb begin
    lfsr_used = 1'b0;
    if (policy_q == mpts_pkg::POLICY_PRIOP) begin
      b_worse = best_urg_q < rd_urg;
      c_worse = rd_urg < best_urg_q;
    end else begin
      b_worse = best_left_q > rd_left;
      c_worse = rd_left > best_left_q;
    end
    if (b_worse) cand_wins = 1'b1;
    else if (c_worse) cand_wins = 1'b0;
    else if (rd_arr != best_arr_q) cand_wins = rd_arr < best_arr_q;
    else if (rd_len != best_len_q) cand_wins = rd_len < best_len_q;
    else begin
      lfsr_used = 1'b1;
      cand_wins = lfsr_q[0];
    end
  end

  always_comb begin
    if (policy_q == mpts_pkg::POLICY_PRIOP) vic_worse = rd_urg < ref_urg_q;
    else vic_worse = rd_left > ref_left_q;
    vic_worse = vic_worse && cvalid_q[idx_c];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q    <= mpts_pkg::POLICY_SRTF;
      cpu_count_q <= mpts_pkg::CNT_W'(1);
      lfsr_q      <= RW'(1);
      cvalid_q    <= '0;
      ready_len_q <= '0;
      done_q      <= '0;
      loaded_q    <= '0;
      clock_q     <= '0;
      idx_q       <= '0;
      vic_found_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          mpts_pkg::CFG_POLICY: policy_q <= cfg_data_i[0];
          mpts_pkg::CFG_CPUS:   cpu_count_q <= cfg_data_i[mpts_pkg::CNT_W-1:0];
          mpts_pkg::CFG_SEED:   lfsr_q <= (cfg_data_i == '0) ? RW'(1) : cfg_data_i;
          default: ;
        endcase
      end
      if (out_ready_i) out_valid_o <= 1'b0;
      case (cmd_i.op)
        mpts_pkg::OP_ACCEPT: begin
          idx_q <= '0;
          if (func_i == mpts_pkg::FUNC_LOAD && load_room) loaded_q <= loaded_q + 1'b1;
        end
        mpts_pkg::OP_ADMIT: begin
          idx_q <= idx_q + 1'b1;
          if (admit_hit && 32'(ready_len_q) < MAX_TASKS) ready_len_q <= ready_len_q + 1'b1;
        end
        mpts_pkg::OP_SEL_INIT: idx_q <= IW'(1);
        mpts_pkg::OP_SEL_STEP: begin
          idx_q <= idx_q + 1'b1;
          if (lfsr_used) lfsr_q <= lfsr_next;
        end
        mpts_pkg::OP_PLACE: begin
          if (free_found) begin
            cvalid_q[free_cpu] <= 1'b1;
            ready_len_q        <= ready_len_q - 1'b1;
          end else begin
            idx_q       <= '0;
            vic_found_q <= 1'b0;
          end
        end
        mpts_pkg::OP_VIC_STEP: begin
          idx_q <= idx_q + 1'b1;
          if (vic_worse) vic_found_q <= 1'b1;
        end
        mpts_pkg::OP_RUN_STEP: begin
          idx_q <= idx_q + 1'b1;
          if (cvalid_q[idx_c] && new_left == '0) begin
            cvalid_q[idx_c] <= 1'b0;
            done_q          <= done_q + 1'b1;
          end
        end
        mpts_pkg::OP_EMIT_ONE: out_valid_o <= 1'b1;
        mpts_pkg::OP_EMIT_CPU: begin
          out_valid_o <= 1'b1;
          idx_q       <= idx_q + 1'b1;
          if (idx_last) clock_q <= clock_q + 1'b1;
        end
        mpts_pkg::OP_CNT_CLR: idx_q <= '0;
        default: ;
      endcase
    end
  end

  // Tables, candidate registers and output payload.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      mpts_pkg::OP_ACCEPT: begin
        if (func_i == mpts_pkg::FUNC_TICK) res_kind_q <= mpts_pkg::KIND_ALL_DONE;
        else if (load_room) res_kind_q <= mpts_pkg::KIND_LOAD_OK;
        else res_kind_q <= mpts_pkg::KIND_LOAD_FULL;
        if (func_i == mpts_pkg::FUNC_LOAD && load_room) begin
          ident_q[loaded_q[TW-1:0]] <= task_id_i;
          arr_q[loaded_q[TW-1:0]]   <= arrival_time_i;
          len_q[loaded_q[TW-1:0]]   <= duration_i;
          left_q[loaded_q[TW-1:0]]  <= duration_i;
          urg_q[loaded_q[TW-1:0]]   <= priority_req_i;
          stat_q[loaded_q[TW-1:0]]  <= mpts_pkg::ST_NEW;
        end
      end
      mpts_pkg::OP_ADMIT: begin
        if (admit_hit) begin
          stat_q[idx_t] <= mpts_pkg::ST_READY;
          if (32'(ready_len_q) < MAX_TASKS) rq_q[ready_len_q[TW-1:0]] <= idx_t;
        end
      end
      mpts_pkg::OP_SEL_INIT: begin
        best_pos_q  <= '0;
        best_task_q <= rd_idx;
        best_urg_q  <= rd_urg;
        best_left_q <= rd_left;
        best_arr_q  <= rd_arr;
        best_len_q  <= rd_len;
      end
      mpts_pkg::OP_SEL_STEP: begin
        if (cand_wins) begin
          best_pos_q  <= idx_t;
          best_task_q <= rd_idx;
          best_urg_q  <= rd_urg;
          best_left_q <= rd_left;
          best_arr_q  <= rd_arr;
          best_len_q  <= rd_len;
        end
      end
      mpts_pkg::OP_PLACE: begin
        if (free_found) begin
          slot_q[free_cpu]    <= best_task_q;
          stat_q[best_task_q] <= mpts_pkg::ST_RUN;
          for (int k = 0; k < MAX_TASKS - 1; k++) begin
            if (k >= best_pos_q) rq_q[k] <= rq_q[k + 1];
          end
        end else begin
          ref_urg_q  <= best_urg_q;
          ref_left_q <= best_left_q;
        end
      end
      mpts_pkg::OP_VIC_STEP: begin
        if (vic_worse) begin
          ref_urg_q  <= rd_urg;
          ref_left_q <= rd_left;
          victim_q   <= idx_c;
        end
      end
      mpts_pkg::OP_SWAP1: begin
        // The preempted task leaves its processor and rejoins the queue tail.
        stat_q[slot_q[victim_q]] <= mpts_pkg::ST_READY;
        for (int k = 0; k < MAX_TASKS - 1; k++) begin
          if (k >= best_pos_q) rq_q[k] <= rq_q[k + 1];
        end
        rq_q[rq_tail]    <= slot_q[victim_q];
        slot_q[victim_q] <= best_task_q;
      end
      mpts_pkg::OP_SWAP2: stat_q[best_task_q] <= mpts_pkg::ST_RUN;
      mpts_pkg::OP_RUN_STEP: begin
        if (cvalid_q[idx_c]) begin
          left_q[rd_idx]  <= new_left;
          r_id_q[idx_c]   <= rd_ident;
          r_rem_q[idx_c]  <= new_left;
          r_busy_q[idx_c] <= 1'b1;
          r_fin_q[idx_c]  <= (new_left == '0);
          if (new_left == '0) stat_q[rd_idx] <= mpts_pkg::ST_DONE;
        end else begin
          r_id_q[idx_c]   <= '0;
          r_rem_q[idx_c]  <= '0;
          r_busy_q[idx_c] <= 1'b0;
          r_fin_q[idx_c]  <= 1'b0;
        end
      end
      mpts_pkg::OP_EMIT_ONE: begin
        kind_o       <= res_kind_q;
        cpu_index_o  <= '0;
        running_id_o <= '0;
        remaining_o  <= '0;
        busy_res_o   <= 1'b0;
        finished_o   <= 1'b0;
        tick_value_o <= clock_q;
        all_done_o   <= all_fin;
        last_o       <= 1'b1;
      end
      mpts_pkg::OP_EMIT_CPU: begin
        kind_o       <= mpts_pkg::KIND_CPU;
        cpu_index_o  <= mpts_pkg::CPU_IDX_W'(idx_q);
        running_id_o <= r_id_q[idx_c];
        remaining_o  <= r_rem_q[idx_c];
        busy_res_o   <= r_busy_q[idx_c];
        finished_o   <= r_fin_q[idx_c];
        tick_value_o <= clock_q;
        all_done_o   <= all_fin;
        last_o       <= idx_last;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_o.is_tick       = (func_i == mpts_pkg::FUNC_TICK);
    st_o.all_fin       = all_fin;
    st_o.idx_ge_loaded = (idx_q >= loaded_q);
    st_o.idx_ge_ready  = (idx_q >= ready_len_q);
    st_o.ready_empty   = (ready_len_q == '0);
    st_o.free_found    = free_found;
    st_o.vic_found     = vic_found_q;
    st_o.idx_ge_ncpu   = (idx_q >= ncpu);
    st_o.idx_last      = idx_last;
    st_o.out_free      = out_free;
  end

  `MPTS_ASSERT(a_queue_bound, ready_len_q <= loaded_q)
  `MPTS_ASSERT(a_task_balance, ($countones(cvalid_q) + done_q) <= loaded_q)
  `MPTS_ASSERT(a_loaded_grows, 1'b1 |=> loaded_q >= $past(loaded_q))

endmodule

`default_nettype wire

/* hdl/multicore_preemptive_task_scheduler.sv */
// ---------------------------------------------------------------------------
// multicore_preemptive_task_scheduler
// Preemptive priority / shortest-remaining-time scheduler for several CPUs.
// ---------------------------------------------------------------------------
// Usage: an input item with func 0 loads one task into the table and yields
// one item (accepted or table full). An item with func 1 advances one tick:
// tasks arriving now join the ready queue, the best ready tasks fill idle
// processors or preempt the strictly worst running task, then each busy
// processor runs one tick. A tick yields one report item per processor in
// use, the final one flagged by last, or a single all-done item.
// The configuration channel sets the policy, the processor count and the
// tie-break seed; the user must write it only while the block is idle, and
// the block itself does not enforce this. A load result is registered in the
// reporting state after acceptance, once the output register is free. A tick
// scans the loaded tasks, the ready queue and the processors in turn; the
// single-read-port task table is scanned one entry per cycle.
// The next item is accepted once the last result sits in the output register.
// Reset empties the table and queue, idles every processor, zeroes the
// clock, and sets SRTF, one processor and seed 1. A stalled receiver holds
// the output register and the sequencer waits with it.
// ---------------------------------------------------------------------------
`default_nettype none

module multicore_preemptive_task_scheduler #(
  parameter int MAX_TASKS = mpts_pkg::MAX_TASKS_DEF,
  parameter int MAX_CPUS  = mpts_pkg::MAX_CPUS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             func_i,
  input  wire logic [mpts_pkg::ID_W-1:0]        task_id_i,
  input  wire logic [mpts_pkg::TIME_BITS-1:0]   arrival_time_i,
  input  wire logic [mpts_pkg::TIME_BITS-1:0]   duration_i,
  input  wire logic [mpts_pkg::PRIO_W-1:0]      priority_req_i,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [mpts_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [mpts_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [mpts_pkg::KIND_W-1:0]           kind_o,
  output logic [mpts_pkg::CPU_IDX_W-1:0]        cpu_index_o,
  output logic [mpts_pkg::ID_W-1:0]             running_id_o,
  output logic [mpts_pkg::TIME_BITS-1:0]        remaining_o,
  output logic                                  busy_res_o,
  output logic                                  finished_o,
  output logic [mpts_pkg::TIME_BITS-1:0]        tick_value_o,
  output logic                                  all_done_o,
  output logic                                  last_o
);

  mpts_pkg::cmd_t  cmd;
  mpts_pkg::stat_t st;

  // Configuration registers are plain flops, so a write is always taken.
  assign cfg_ready_o = 1'b1;

  mpts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  mpts_dp #(
    .MAX_TASKS (MAX_TASKS),
    .MAX_CPUS  (MAX_CPUS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .func_i         (func_i),
    .task_id_i      (task_id_i),
    .arrival_time_i (arrival_time_i),
    .duration_i     (duration_i),
    .priority_req_i (priority_req_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .kind_o         (kind_o),
    .cpu_index_o    (cpu_index_o),
    .running_id_o   (running_id_o),
    .remaining_o    (remaining_o),
    .busy_res_o     (busy_res_o),
    .finished_o     (finished_o),
    .tick_value_o   (tick_value_o),
    .all_done_o     (all_done_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire
